// ===== hdl/gasa_pkg.sv =====
`timescale 1ns / 1ps

package gasa_pkg;

    // Fixed field widths of the request and response items
    localparam int SYM_W    = 16;
    localparam int GEO_W    = 10;
    localparam int MET_W    = 16;
    localparam int PAGE_W   = 7;
    localparam int XY_W     = 9;

    // Valid bits are kept as 32-bit rows, one row per memory word
    localparam int VROW_W   = 32;
    localparam int VBIT_W   = 5;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_PLACED = 2'd1,
        ST_RANGE  = 2'd2,
        ST_FULL   = 2'd3
    } gasa_status_t;

    typedef struct packed {
        logic [SYM_W-1:0]        symbol;
        logic [GEO_W-1:0]        glyph_width;
        logic [GEO_W-1:0]        glyph_height;
        logic [MET_W-1:0]        glyph_advance;
        logic signed [MET_W-1:0] glyph_offset_y;
    } gasa_in_t;

    typedef struct packed {
        gasa_status_t            status;
        logic [PAGE_W-1:0]       page;
        logic [XY_W-1:0]         x_pos;
        logic [XY_W-1:0]         y_pos;
        logic [GEO_W-1:0]        width_out;
        logic [GEO_W-1:0]        height_out;
        logic [MET_W-1:0]        advance_out;
        logic signed [MET_W-1:0] offset_y_out;
    } gasa_out_t;

    // Queue entry: request plus front-end classification
    typedef struct packed {
        gasa_in_t item;
        logic     out_of_range;
    } gasa_req_t;

    // Back-end control toward the front end
    typedef struct packed {
        logic pop;
        logic accept_ok;
    } gasa_bk_ctl_t;

    // One cache entry as stored in the entry memory
    typedef struct packed {
        logic [PAGE_W-1:0]       page;
        logic [XY_W-1:0]         x_pos;
        logic [XY_W-1:0]         y_pos;
        logic [GEO_W-1:0]        width;
        logic [GEO_W-1:0]        height;
        logic [MET_W-1:0]        advance;
        logic signed [MET_W-1:0] offset_y;
    } gasa_entry_t;

    localparam int ENTRY_W = $bits(gasa_entry_t);

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_LOOK  = 2'd2
    } gasa_bk_state_t;

endpackage

// ===== hdl/gasa_ram.sv =====
`timescale 1ns / 1ps

module gasa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/gasa_front.sv =====
`timescale 1ns / 1ps

module gasa_front import gasa_pkg::*; #(
    parameter int GLYPH_SLOTS = 32768
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  gasa_in_t     req,
    input  gasa_bk_ctl_t bk_ctl,
    output logic         q_valid,
    output gasa_req_t    q
);

    localparam logic [SYM_W:0] SLOTS_LIM = (SYM_W+1)'(GLYPH_SLOTS);
    localparam logic [1:0]     Q_FULL    = 2'd2;

    gasa_req_t  q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    gasa_req_t  entry;

    assign req_stall = (count_reg == Q_FULL) || !bk_ctl.accept_ok;
    assign push      = req_valid && !req_stall;

    // classify: symbols past the table are flagged here
    always_comb
    begin
        entry.item         = req;
        entry.out_of_range = ({1'b0, req.symbol} >= SLOTS_LIM);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (bk_ctl.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !bk_ctl.pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && bk_ctl.pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q       = q_mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/gasa_back.sv =====
`timescale 1ns / 1ps

module gasa_back import gasa_pkg::*; #(
    parameter int ATLAS_SIZE  = 512,
    parameter int GAP         = 2,
    parameter int GLYPH_SLOTS = 32768,
    parameter int MAX_PAGES   = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  gasa_req_t    q,
    output gasa_bk_ctl_t bk_ctl,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output gasa_out_t    rsp
);

    localparam int IW    = $clog2(GLYPH_SLOTS);
    localparam int RW    = IW - VBIT_W;
    localparam int VROWS = (GLYPH_SLOTS + VROW_W - 1) / VROW_W;
    localparam int CW    = $clog2(ATLAS_SIZE + 1);
    localparam int SW    = ((CW > GEO_W) ? CW : GEO_W) + 2;

    localparam logic [SW-1:0]     ATLAS_L   = SW'(ATLAS_SIZE);
    localparam logic [SW-1:0]     GAP_L     = SW'(GAP);
    localparam logic [RW-1:0]     CLR_LAST  = RW'(VROWS - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(MAX_PAGES - 1);

    function automatic logic [CW-1:0] sat(input logic [SW-1:0] v);
        return (v > ATLAS_L) ? CW'(ATLAS_SIZE) : CW'(v);
    endfunction

    gasa_bk_state_t    state_reg, state_next;
    logic [RW-1:0]     clr_cnt_reg, clr_cnt_next;
    gasa_req_t         cur_reg;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     bottom_reg, bottom_next;
    logic [CW-1:0]     top_reg, top_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              open_reg, open_next;
    logic              rsp_valid_reg, rsp_valid_next;
    gasa_out_t         rsp_reg, rsp_next;

    // memory ports
    logic              v_we;
    logic [RW-1:0]     v_waddr;
    logic [VROW_W-1:0] v_wdata;
    logic [VROW_W-1:0] v_rdata;
    logic              e_we;
    logic [ENTRY_W-1:0] e_wdata;
    logic [ENTRY_W-1:0] e_rdata;
    gasa_entry_t       e_rd;
    gasa_entry_t       e_new;

    logic [IW-1:0]     cur_idx;
    logic              hit;

    // placement
    logic              fit_x, fit_y, fit_t;
    logic              need_page;
    logic              exhausted;
    logic [CW-1:0]     p_left, p_bottom, p_top;
    logic [PAGE_W-1:0] p_page;
    logic [SW-1:0]     grow;
    logic [CW-1:0]     new_left, new_top;

    gasa_ram #(
        .WIDTH (VROW_W),
        .DEPTH (VROWS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (q.item.symbol[IW-1:VBIT_W]),
        .rdata (v_rdata)
    );

    gasa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (cur_idx),
        .wdata (e_wdata),
        .raddr (q.item.symbol[IW-1:0]),
        .rdata (e_rdata)
    );

    assign cur_idx = cur_reg.item.symbol[IW-1:0];
    assign hit     = v_rdata[cur_reg.item.symbol[VBIT_W-1:0]];
    assign e_rd    = gasa_entry_t'(e_rdata);
    assign e_wdata = e_new;

    // shelf decision
    always_comb
    begin
        fit_x = (SW'(left_reg) + SW'(cur_reg.item.glyph_width)) < ATLAS_L;
        fit_y = (SW'(bottom_reg) + SW'(cur_reg.item.glyph_height)) < ATLAS_L;
        fit_t = (SW'(top_reg) + SW'(cur_reg.item.glyph_height)) < ATLAS_L;

        need_page = 1'b0;
        p_left    = left_reg;
        p_bottom  = bottom_reg;
        p_top     = top_reg;
        p_page    = page_reg;

        priority if (!open_reg)
        begin
            need_page = 1'b1;
        end
        else if (fit_x && fit_y)
        begin
            need_page = 1'b0;
        end
        else if (!fit_x && fit_t)
        begin
            p_left   = '0;
            p_bottom = top_reg;
        end
        else
        begin
            need_page = 1'b1;
        end

        if (need_page)
        begin
            p_left   = '0;
            p_bottom = '0;
            p_top    = '0;
            p_page   = open_reg ? (page_reg + PAGE_W'(1)) : '0;
        end

        exhausted = need_page && open_reg && (page_reg == PAGE_LAST);

        new_left = sat(SW'(p_left) + SW'(cur_reg.item.glyph_width) + GAP_L);
        grow     = SW'(p_bottom) + SW'(cur_reg.item.glyph_height) + GAP_L;
        new_top  = (SW'(p_top) < grow) ? sat(grow) : p_top;

        e_new.page     = p_page;
        e_new.x_pos    = XY_W'(p_left);
        e_new.y_pos    = XY_W'(p_bottom);
        e_new.width    = cur_reg.item.glyph_width;
        e_new.height   = cur_reg.item.glyph_height;
        e_new.advance  = cur_reg.item.glyph_advance;
        e_new.offset_y = cur_reg.item.glyph_offset_y;
    end

    // sequencer: clearing pass, issue lookup, resolve and write back
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        bk_ctl.pop     = 1'b0;
        bk_ctl.accept_ok = (state_reg != BK_CLEAR);
        v_we           = 1'b0;
        v_waddr        = cur_reg.item.symbol[IW-1:VBIT_W];
        v_wdata        = v_rdata | (VROW_W'(1) << cur_reg.item.symbol[VBIT_W-1:0]);
        e_we           = 1'b0;
        left_next      = left_reg;
        bottom_next    = bottom_reg;
        top_next       = top_reg;
        page_next      = page_reg;
        open_next      = open_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            BK_CLEAR:
            begin
                v_we    = 1'b1;
                v_waddr = clr_cnt_reg;
                v_wdata = '0;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + RW'(1);
                end
            end
            BK_IDLE:
            begin
                if (q_valid && (!rsp_valid_reg || !rsp_stall))
                begin
                    bk_ctl.pop = 1'b1;
                    state_next = BK_LOOK;
                end
            end
            BK_LOOK:
            begin
                state_next     = BK_IDLE;
                rsp_valid_next = 1'b1;
                rsp_next       = '0;
                priority if (cur_reg.out_of_range)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else if (hit)
                begin
                    rsp_next.status       = ST_HIT;
                    rsp_next.page         = e_rd.page;
                    rsp_next.x_pos        = e_rd.x_pos;
                    rsp_next.y_pos        = e_rd.y_pos;
                    rsp_next.width_out    = e_rd.width;
                    rsp_next.height_out   = e_rd.height;
                    rsp_next.advance_out  = e_rd.advance;
                    rsp_next.offset_y_out = e_rd.offset_y;
                end
                else if (exhausted)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    v_we        = 1'b1;
                    e_we        = 1'b1;
                    left_next   = new_left;
                    bottom_next = p_bottom;
                    top_next    = new_top;
                    page_next   = p_page;
                    open_next   = 1'b1;
                    rsp_next.status       = ST_PLACED;
                    rsp_next.page         = e_new.page;
                    rsp_next.x_pos        = e_new.x_pos;
                    rsp_next.y_pos        = e_new.y_pos;
                    rsp_next.width_out    = e_new.width;
                    rsp_next.height_out   = e_new.height;
                    rsp_next.advance_out  = e_new.advance;
                    rsp_next.offset_y_out = e_new.offset_y;
                end
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            left_reg      <= '0;
            bottom_reg    <= '0;
            top_reg       <= '0;
            page_reg      <= '0;
            open_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            left_reg      <= left_next;
            bottom_reg    <= bottom_next;
            top_reg       <= top_next;
            page_reg      <= page_next;
            open_reg      <= open_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bk_ctl.pop)
        begin
            cur_reg <= q;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/glyph_atlas_shelf_allocator_core.sv =====
`timescale 1ns / 1ps

// Glyph atlas shelf allocator: glyph cache with shelf packing into square pages.
// Request channel (req_valid / req_stall / req): symbol, bitmap size, advance and
// vertical offset. Response channel (rsp_valid / rsp_stall / rsp): one item per
// request, in order: hit, newly placed, symbol out of range, or pages exhausted.
// A front end takes requests into a two-entry queue and flags symbols past the
// table; a back end looks the symbol up in the entry and valid memories, places
// misses on the current shelf, a new shelf or a new page, writes the entry back
// and loads the output register.
// An accepted request passes the queue, the lookup register with its registered
// memory reads, and the output register. The back end takes no new item until
// the last one is written back, so the next lookup reads the updated memory.
// A stalled response holds in the output register; the queue keeps taking
// requests until it holds two, then req_stall rises.
// Reset: after rst_n releases, the valid memory is swept one 32-bit row a cycle,
// all GLYPH_SLOTS/32 rows (1024 by default), with req_stall held high. Shelf
// cursors return to zero and no page is open.
module glyph_atlas_shelf_allocator_core import gasa_pkg::*; #(
    parameter int ATLAS_SIZE  = 512,
    parameter int GAP         = 2,
    parameter int GLYPH_SLOTS = 32768,
    parameter int MAX_PAGES   = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  gasa_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output gasa_out_t rsp
);

    gasa_bk_ctl_t bk_ctl;   // pop and accept enable from back end
    logic         q_valid;  // queue holds an item
    gasa_req_t    q;        // queue head

    // Front end: accept and classify
    gasa_front #(
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .bk_ctl    (bk_ctl),
        .q_valid   (q_valid),
        .q         (q)
    );

    // Back end: lookup, placement, write-back, output register
    gasa_back #(
        .ATLAS_SIZE  (ATLAS_SIZE),
        .GAP         (GAP),
        .GLYPH_SLOTS (GLYPH_SLOTS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q         (q),
        .bk_ctl    (bk_ctl),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // no request taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_ctl.accept_ok |-> req_stall)
        else $error("request accepted during valid clear");

    // lookups are never popped in consecutive cycles, for read-after-write safety
    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctl.pop |=> !bk_ctl.pop)
        else $error("back end popped in consecutive cycles");

    // only a queue with an item is popped
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctl.pop |-> q_valid)
        else $error("pop of empty queue");

    // rejected requests carry zero placement
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_RANGE || rsp.status == ST_FULL)
        |-> (rsp.page == '0) && (rsp.x_pos == '0) && (rsp.y_pos == '0)
            && (rsp.width_out == '0) && (rsp.advance_out == '0))
        else $error("rejected response with nonzero fields");

endmodule
